@@ rtl/su2q_pkg.sv @@
// ============================================================================
// su2q_pkg: shared types and constants for the SU(2) quaternion ALU
// Number format, lane operand bundle, pipeline tag and opcode encoding.
// ============================================================================
package su2q_pkg;

    localparam int COMP_WIDTH = 32;
    localparam int FRAC_BITS  = COMP_WIDTH - 4;
    localparam int PROD_W     = 2 * COMP_WIDTH;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int ACC_W      = PROD_W + 3;
    localparam int NUM_LANES  = 4;
    localparam int NUM_TERMS  = 4;

    // Clock edges from the start beat to the edge that takes the result.
    localparam int ACCEPT_TO_RESULT = 5;

    localparam logic [COMP_WIDTH-1:0] FIX_ONE = COMP_WIDTH'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [COMP_WIDTH-1:0] SAT_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic [COMP_WIDTH-1:0] SAT_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        FUNC_SUM   = 3'd0,
        FUNC_PROD  = 3'd1,
        FUNC_SCALE = 3'd2,
        FUNC_CONJ  = 3'd3,
        FUNC_DET   = 3'd4,
        FUNC_TRACE = 3'd5
    } func_t;

    // Four signed products summed by one lane; sub negates a product.
    typedef struct packed {
        logic [NUM_TERMS-1:0][COMP_WIDTH-1:0] x;
        logic [NUM_TERMS-1:0][COMP_WIDTH-1:0] y;
        logic [NUM_TERMS-1:0]                 sub;
    } lane_op_t;

    typedef struct packed {
        logic valid;
        logic is_scalar;
    } tag_t;

endpackage

@@ rtl/su2_quaternion_alu_unit.sv @@
// ============================================================================
// su2_quaternion_alu_unit: SU(2) element arithmetic in signed fixed point
// Sum, product, complex scale, conjugate, determinant and trace on a fully
// pipelined set of four multiply-accumulate lanes.
// ============================================================================
// A start beat passes the route register, the lane stages and the merge
// register; the result is then driven with done high for one cycle.
// Throughput: one item per cycle; busy stays low, each lane holds 4 multipliers.
// Reset clears the pipeline valid bits only; no result is lost mid-flight
// except by reset. The receiver cannot stall, so nothing is held back.
module su2_quaternion_alu_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [2:0]                             func,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        b0,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        b1,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        b2,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        b3,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        c0,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        c1,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        c2,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        c3,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        k_re,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        k_im,
    output logic                                   done,
    output logic [su2q_pkg::COMP_WIDTH-1:0]        r0,
    output logic [su2q_pkg::COMP_WIDTH-1:0]        r1,
    output logic [su2q_pkg::COMP_WIDTH-1:0]        r2,
    output logic [su2q_pkg::COMP_WIDTH-1:0]        r3,
    output logic [su2q_pkg::COMP_WIDTH-1:0]        scalar,
    output logic                                   overflow
);

    localparam int TAG_STAGES = 3;

    logic                                                        take;
    su2q_pkg::lane_op_t [su2q_pkg::NUM_LANES-1:0]                lane_op;
    su2q_pkg::tag_t                                              route_tag;
    su2q_pkg::tag_t                                              tag_reg [TAG_STAGES];
    logic [su2q_pkg::NUM_LANES-1:0][su2q_pkg::ACC_W-1:0]         lane_acc;
    logic [su2q_pkg::NUM_LANES-1:0][su2q_pkg::COMP_WIDTH-1:0]    r;

    assign busy = 1'b0;
    assign take = start & ~busy;

    su2q_route u_route (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .func    (func),
        .b0      (b0),
        .b1      (b1),
        .b2      (b2),
        .b3      (b3),
        .c0      (c0),
        .c1      (c1),
        .c2      (c2),
        .c3      (c3),
        .k_re    (k_re),
        .k_im    (k_im),
        .lane_op (lane_op),
        .tag     (route_tag)
    );

    for (genvar l = 0; l < su2q_pkg::NUM_LANES; l++)
    begin : g_lane
        su2q_lane u_lane (
            .clk (clk),
            .op  (lane_op[l]),
            .acc (lane_acc[l])
        );
    end

    // Advance the tag alongside the three lane stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TAG_STAGES; s++)
            begin
                tag_reg[s] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= route_tag;
            for (int s = 1; s < TAG_STAGES; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    su2q_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag      (tag_reg[TAG_STAGES-1]),
        .acc      (lane_acc),
        .done     (done),
        .r        (r),
        .scalar   (scalar),
        .overflow (overflow)
    );

    assign r0 = r[0];
    assign r1 = r[1];
    assign r2 = r[2];
    assign r3 = r[3];

endmodule

@@ rtl/su2q_route.sv @@
// ============================================================================
// su2q_route: opcode decode and operand routing
// Maps each opcode onto four sum-of-products lanes and registers the result.
// Exact operations use products with fixed-point one, so rounding is a no-op.
// ============================================================================
module su2q_route (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  take,
    input  logic [2:0]                                            func,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]                       b0,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]                       b1,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]                       b2,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]                       b3,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]                       c0,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]                       c1,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]                       c2,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]                       c3,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]                       k_re,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]                       k_im,
    output su2q_pkg::lane_op_t [su2q_pkg::NUM_LANES-1:0]          lane_op,
    output su2q_pkg::tag_t                                        tag
);

    // Product index tables: lane, term -> component of b, component of c.
    localparam logic [1:0] PROD_B [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd3, 2'd2},
        '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd0, 2'd3, 2'd2, 2'd1}
    };
    localparam logic [1:0] PROD_C [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd2, 2'd3},
        '{2'd2, 2'd0, 2'd3, 2'd1},
        '{2'd3, 2'd0, 2'd1, 2'd2}
    };
    localparam logic [3:0] PROD_SUB [4] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

    logic [3:0][su2q_pkg::COMP_WIDTH-1:0]              bv;
    logic [3:0][su2q_pkg::COMP_WIDTH-1:0]              cv;
    su2q_pkg::lane_op_t [su2q_pkg::NUM_LANES-1:0]      lane_op_next;
    su2q_pkg::lane_op_t [su2q_pkg::NUM_LANES-1:0]      lane_op_reg;
    su2q_pkg::tag_t                                    tag_next;
    su2q_pkg::tag_t                                    tag_reg;

    assign bv = {b3, b2, b1, b0};
    assign cv = {c3, c2, c1, c0};

    always_comb
    begin
        lane_op_next = '0;
        unique case (func)
            su2q_pkg::FUNC_SUM:
            begin
                for (int l = 0; l < su2q_pkg::NUM_LANES; l++)
                begin
                    lane_op_next[l].x[0] = bv[l];
                    lane_op_next[l].y[0] = su2q_pkg::FIX_ONE;
                    lane_op_next[l].x[1] = cv[l];
                    lane_op_next[l].y[1] = su2q_pkg::FIX_ONE;
                end
            end
            su2q_pkg::FUNC_PROD:
            begin
                for (int l = 0; l < su2q_pkg::NUM_LANES; l++)
                begin
                    for (int t = 0; t < su2q_pkg::NUM_TERMS; t++)
                    begin
                        lane_op_next[l].x[t]   = bv[PROD_B[l][t]];
                        lane_op_next[l].y[t]   = cv[PROD_C[l][t]];
                        lane_op_next[l].sub[t] = PROD_SUB[l][t];
                    end
                end
            end
            su2q_pkg::FUNC_SCALE:
            begin
                for (int l = 0; l < su2q_pkg::NUM_LANES; l++)
                begin
                    lane_op_next[l].x[0]   = k_re;
                    lane_op_next[l].y[0]   = cv[l];
                    lane_op_next[l].x[1]   = k_im;
                    lane_op_next[l].y[1]   = cv[3 - l];
                    lane_op_next[l].sub[1] = (l < 2);
                end
            end
            su2q_pkg::FUNC_CONJ:
            begin
                for (int l = 0; l < su2q_pkg::NUM_LANES; l++)
                begin
                    lane_op_next[l].x[0]   = bv[l];
                    lane_op_next[l].y[0]   = su2q_pkg::FIX_ONE;
                    lane_op_next[l].sub[0] = (l != 0);
                end
            end
            su2q_pkg::FUNC_DET:
            begin
                for (int t = 0; t < su2q_pkg::NUM_TERMS; t++)
                begin
                    lane_op_next[0].x[t] = bv[t];
                    lane_op_next[0].y[t] = bv[t];
                end
            end
            su2q_pkg::FUNC_TRACE:
            begin
                lane_op_next[0].x[0] = b0;
                lane_op_next[0].y[0] = su2q_pkg::FIX_ONE;
                lane_op_next[0].x[1] = b0;
                lane_op_next[0].y[1] = su2q_pkg::FIX_ONE;
            end
            default:
            begin
                // Unused opcodes: all lanes stay zero.
                lane_op_next = '0;
            end
        endcase
    end

    always_comb
    begin
        tag_next.valid     = take;
        tag_next.is_scalar = (func == su2q_pkg::FUNC_DET) || (func == su2q_pkg::FUNC_TRACE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_op_reg <= lane_op_next;
    end

    assign lane_op = lane_op_reg;
    assign tag     = tag_reg;

endmodule

@@ rtl/su2q_lane.sv @@
// ============================================================================
// su2q_lane: one sum-of-products lane
// Four signed multipliers, a pairwise add/subtract stage and a final add
// that also folds in the rounding half LSB. Three register stages.
// ============================================================================
module su2q_lane (
    input  logic                            clk,
    input  su2q_pkg::lane_op_t              op,
    output logic [su2q_pkg::ACC_W-1:0]      acc
);

    logic signed [su2q_pkg::PROD_W-1:0] prod_next [su2q_pkg::NUM_TERMS];
    logic signed [su2q_pkg::PROD_W-1:0] prod_reg  [su2q_pkg::NUM_TERMS];
    logic [su2q_pkg::NUM_TERMS-1:0]     sub_reg;
    logic signed [su2q_pkg::PAIR_W-1:0] term      [su2q_pkg::NUM_TERMS];
    logic signed [su2q_pkg::PAIR_W-1:0] pair_next [2];
    logic signed [su2q_pkg::PAIR_W-1:0] pair_reg  [2];
    logic signed [su2q_pkg::ACC_W-1:0]  acc_next;
    logic signed [su2q_pkg::ACC_W-1:0]  acc_reg;

    always_comb
    begin
        for (int t = 0; t < su2q_pkg::NUM_TERMS; t++)
        begin
            prod_next[t] = $signed(op.x[t]) * $signed(op.y[t]);
        end
    end

    always_comb
    begin
        for (int t = 0; t < su2q_pkg::NUM_TERMS; t++)
        begin
            term[t] = sub_reg[t] ? -su2q_pkg::PAIR_W'(prod_reg[t])
                                 :  su2q_pkg::PAIR_W'(prod_reg[t]);
        end
        pair_next[0] = term[0] + term[1];
        pair_next[1] = term[2] + term[3];
        acc_next     = su2q_pkg::ACC_W'(pair_reg[0]) + su2q_pkg::ACC_W'(pair_reg[1])
                     + su2q_pkg::ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sub_reg  <= op.sub;
        pair_reg <= pair_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

@@ rtl/su2q_merge.sv @@
// ============================================================================
// su2q_merge: round, saturate and merge the lane results
// Drops the fraction bits, clamps each lane to the component range, steers
// lane zero to the scalar port for determinant and trace, ORs the overflows.
// ============================================================================
module su2q_merge (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  su2q_pkg::tag_t                                      tag,
    input  logic [su2q_pkg::NUM_LANES-1:0][su2q_pkg::ACC_W-1:0] acc,
    output logic                                                done,
    output logic [su2q_pkg::NUM_LANES-1:0][su2q_pkg::COMP_WIDTH-1:0] r,
    output logic [su2q_pkg::COMP_WIDTH-1:0]                     scalar,
    output logic                                                overflow
);

    logic signed [su2q_pkg::ACC_W-1:0]                         shifted [su2q_pkg::NUM_LANES];
    logic [su2q_pkg::NUM_LANES-1:0][su2q_pkg::COMP_WIDTH-1:0]  val;
    logic [su2q_pkg::NUM_LANES-1:0]                            sat;
    logic [su2q_pkg::NUM_LANES-1:0][su2q_pkg::COMP_WIDTH-1:0]  r_next;
    logic [su2q_pkg::COMP_WIDTH-1:0]                           scalar_next;
    logic                                                      done_reg;
    logic [su2q_pkg::NUM_LANES-1:0][su2q_pkg::COMP_WIDTH-1:0]  r_reg;
    logic [su2q_pkg::COMP_WIDTH-1:0]                           scalar_reg;
    logic                                                      overflow_reg;

    always_comb
    begin
        for (int l = 0; l < su2q_pkg::NUM_LANES; l++)
        begin
            shifted[l] = $signed(acc[l]) >>> su2q_pkg::FRAC_BITS;
            // Fits when every bit above the component sign matches it.
            sat[l] = !((&shifted[l][su2q_pkg::ACC_W-1:su2q_pkg::COMP_WIDTH-1])
                     || !(|shifted[l][su2q_pkg::ACC_W-1:su2q_pkg::COMP_WIDTH-1]));
            if (!sat[l])
            begin
                val[l] = shifted[l][su2q_pkg::COMP_WIDTH-1:0];
            end
            else if (shifted[l][su2q_pkg::ACC_W-1])
            begin
                val[l] = su2q_pkg::SAT_MIN;
            end
            else
            begin
                val[l] = su2q_pkg::SAT_MAX;
            end
        end

        if (tag.is_scalar)
        begin
            r_next      = '0;
            scalar_next = val[0];
        end
        else
        begin
            r_next      = val;
            scalar_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        scalar_reg   <= scalar_next;
        overflow_reg <= |sat;
    end

    assign done     = done_reg;
    assign r        = r_reg;
    assign scalar   = scalar_reg;
    assign overflow = overflow_reg;

endmodule

@@ rtl/su2q_checker.sv @@
// ============================================================================
// su2q_port_checker: port-level checks for the SU(2) quaternion ALU
// Watches result timing and the field conventions of each opcode class.
// ============================================================================
module su2q_port_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic [2:0]                             func,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        b0,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        c0,
    input  logic                                   done,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        r0,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        r1,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        r2,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        r3,
    input  logic [su2q_pkg::COMP_WIDTH-1:0]        scalar,
    input  logic                                   overflow
);

    localparam int LAT = su2q_pkg::ACCEPT_TO_RESULT;

    logic [su2q_pkg::COMP_WIDTH-1:0] sum0;

    assign sum0 = b0 + c0;

    // Every result beat traces back to a start beat a fixed time earlier.
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result beat without matching start beat");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("start beat produced no result beat");

    a_scalar_ops_zero_element: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(func, LAT) == su2q_pkg::FUNC_DET
               || $past(func, LAT) == su2q_pkg::FUNC_TRACE))
        |-> (r0 == '0 && r1 == '0 && r2 == '0 && r3 == '0))
        else $error("element fields not zero for a scalar opcode");

    a_unused_op_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(func, LAT) != su2q_pkg::FUNC_SUM
              && $past(func, LAT) != su2q_pkg::FUNC_PROD
              && $past(func, LAT) != su2q_pkg::FUNC_SCALE
              && $past(func, LAT) != su2q_pkg::FUNC_CONJ
              && $past(func, LAT) != su2q_pkg::FUNC_DET
              && $past(func, LAT) != su2q_pkg::FUNC_TRACE)
        |-> (r0 == '0 && r1 == '0 && r2 == '0 && r3 == '0 && scalar == '0 && !overflow))
        else $error("unused opcode gave a nonzero result");

    a_sum_component0: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !overflow && $past(func, LAT) == su2q_pkg::FUNC_SUM)
        |-> (r0 == $past(sum0, LAT) && scalar == '0))
        else $error("sum result component zero mismatch");

endmodule

bind su2_quaternion_alu_unit su2q_port_checker u_su2q_checker (.*);
